/* hdl/assert_macros.svh */
// assertion macros shared by the key scan encoder modules
// no dependencies; included inside module bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define KSME_ASSERT(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("ksme assertion failed");

// antecedent implies consequent on the next edge
`define KSME_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ksme assertion failed");

`endif

/* hdl/ksme_pkg.sv */
// shared types, constants and helpers for the key scan to midi event encoder
// no dependencies
`timescale 1ns / 1ps

package ksme_pkg;

  localparam int NUM_KEYS = 12;
  localparam int KEY_W    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  localparam int PRESSED_W = 12;
  localparam int OCT_W     = 3;
  localparam int CHAN_W    = 4;
  localparam int STATUS_W  = 8;
  localparam int NOTE_W    = 7;
  localparam int VEL_W     = 7;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;

  localparam logic [STATUS_W-1:0] STATUS_NOTE_ON  = 8'h90;
  localparam logic [STATUS_W-1:0] STATUS_NOTE_OFF = 8'h80;
  localparam logic [VEL_W-1:0]    VELOCITY_ON     = 7'd127;
  localparam logic [VEL_W-1:0]    VELOCITY_OFF    = 7'd0;
  localparam logic [NOTE_W-1:0]   NOTE_BASE       = 7'd24;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } ksme_state_t;

  typedef struct packed {
    logic load;
    logic step;
  } ksme_cmd_t;

  typedef struct packed {
    logic out_free;
    logic key_done;
    logic last_key;
  } ksme_sts_t;

  // scan field to internal key vector, keys past the field are never pressed
  function automatic logic [NUM_KEYS-1:0] to_keys(input logic [PRESSED_W-1:0] scan);
    logic [15:0]         ext;
    logic [NUM_KEYS-1:0] r;
    ext = {4'b0, scan};
    for (int i = 0; i < NUM_KEYS; i++) begin
      r[i] = ext[i];
    end
    return r;
  endfunction

  // 12*octave + 24 + key, kept to 7 bits
  function automatic logic [NOTE_W-1:0] note_of(input logic [OCT_W-1:0] oct,
                                                input logic [KEY_W-1:0] key);
    logic [NOTE_W-1:0] o;
    o = {{(NOTE_W-OCT_W){1'b0}}, oct};
    return (o << 3) + (o << 2) + NOTE_BASE + NOTE_W'(key);
  endfunction

endpackage

/* hdl/ksme_ctrl.sv */
// controller for the key walk: idle / walk sequencing
// depends on ksme_pkg and assert_macros.svh
`timescale 1ns / 1ps

module ksme_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  ksme_pkg::ksme_sts_t sts,
  output ksme_pkg::ksme_cmd_t cmd
);
  import ksme_pkg::*;
  `include "assert_macros.svh"

  ksme_state_t state_r, state_nxt;
  logic        walk_end;

  assign in_tready = (state_r == ST_IDLE);
  assign cmd.load  = in_tvalid & in_tready;
  assign cmd.step  = (state_r == ST_WALK) & sts.out_free;
  assign walk_end  = cmd.step & sts.key_done & sts.last_key;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.load) state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (walk_end) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // the scan after the last key ends must be takeable at once
  `KSME_ASSERT_NEXT(a_walk_end_idle, clk, rst_n, walk_end, in_tready)

endmodule

/* hdl/ksme_dp.sv */
// datapath: scan, held keys, octave history, event forming and output register
// depends on ksme_pkg and assert_macros.svh
`timescale 1ns / 1ps

module ksme_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [ksme_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [ksme_pkg::CHAN_W-1:0]         cfg_data,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [ksme_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                out_tlast,
  input  ksme_pkg::ksme_cmd_t                 cmd,
  output ksme_pkg::ksme_sts_t                 sts
);
  import ksme_pkg::*;
  `include "assert_macros.svh"

  logic [NUM_KEYS-1:0] pressed_r, held_r, held_nxt;
  logic [OCT_W-1:0]    oct_r, prev_oct_r;
  logic [CHAN_W-1:0]   chan_r;
  logic [KEY_W-1:0]    key_r, last_key_r, last_key_nxt;
  logic                phase_r;
  logic                changed;

  logic                out_valid_r;
  logic [STATUS_W-1:0] status_r;
  logic [NOTE_W-1:0]   note_r;
  logic [VEL_W-1:0]    vel_r;
  logic                last_r;

  logic [NUM_KEYS-1:0] in_keys, active;
  logic [OCT_W-1:0]    in_oct, ev_oct;
  logic                p, h, has_event, two, ev_on, key_done, at_last_key;

  assign in_keys = to_keys(in_tdata[PRESSED_W-1:0]);
  assign in_oct  = in_tdata[PRESSED_W +: OCT_W];
  assign changed = (oct_r != prev_oct_r);

  // highest key of the incoming scan that will emit anything
  always_comb begin
    last_key_nxt = '0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      active[i] = (in_keys[i] ^ held_r[i]) | (in_oct != prev_oct_r);
      if (active[i]) last_key_nxt = KEY_W'(i);
    end
  end

  // events of the key under walk
  assign p         = pressed_r[key_r];
  assign h         = held_r[key_r];
  assign has_event = (p ^ h) | changed;
  assign two       = p & h & changed;
  assign ev_on     = p & (~h | phase_r);
  // note-off of a released key uses the current octave, other note-offs the old one
  assign ev_oct    = (ev_on | (~p & h)) ? oct_r : prev_oct_r;
  assign key_done  = ~two | phase_r;
  assign at_last_key = (key_r == KEY_W'(NUM_KEYS - 1));

  assign sts.out_free = ~out_valid_r | out_tready;
  assign sts.key_done = key_done;
  assign sts.last_key = at_last_key;

  always_comb begin
    held_nxt = held_r;
    held_nxt[key_r] = p;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= '0;
      prev_oct_r  <= '0;
      chan_r      <= '0;
      out_valid_r <= 1'b0;
      key_r       <= '0;
      phase_r     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) chan_r <= cfg_data;

      if (cmd.load) begin
        pressed_r  <= in_keys;
        oct_r      <= in_oct;
        last_key_r <= last_key_nxt;
        key_r      <= '0;
        phase_r    <= 1'b0;
      end

      if (cmd.step) begin
        if (key_done) begin
          held_r  <= held_nxt;
          phase_r <= 1'b0;
          if (!at_last_key) key_r <= key_r + 1'b1;
          else prev_oct_r <= oct_r;
        end else begin
          phase_r <= 1'b1;
        end
      end

      if (cmd.step && has_event) begin
        out_valid_r <= 1'b1;
        status_r    <= (ev_on ? STATUS_NOTE_ON : STATUS_NOTE_OFF)
                       | {{(STATUS_W-CHAN_W){1'b0}}, chan_r};
        note_r      <= note_of(ev_oct, key_r);
        vel_r       <= ev_on ? VELOCITY_ON : VELOCITY_OFF;
        last_r      <= (key_r == last_key_r) & key_done;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, vel_r, note_r, status_r};
  assign out_tlast  = last_r;

  // a word is never formed over one still waiting
  `KSME_ASSERT(a_no_overwrite, clk, rst_n, !(cmd.step && has_event && out_valid_r && !out_tready))
  // octave history moves on when the walk closes
  `KSME_ASSERT_NEXT(a_prev_oct, clk, rst_n, cmd.step && key_done && at_last_key,
                    prev_oct_r == $past(oct_r))

endmodule

/* hdl/key_scan_to_midi_events.sv */
// Key scan to MIDI note event encoder, top level.
// The scan is loaded first, then the walk steps key 0 and registers its word, if any.
// The key walker visits one key per cycle while the output is free; a key
// with an off/on pair is visited twice, and output back-pressure stalls the walk.
// A new scan is taken only once the walk of the last one has ended.
// Reset (rst_n low, synchronous): no keys held, previous octave 0, channel 0.
`timescale 1ns / 1ps

module key_scan_to_midi_events (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [ksme_pkg::IN_DATA_W-1:0]    in_tdata,   // [11:0] pressed_keys, [14:12] octave
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ksme_pkg::OUT_DATA_W-1:0]   out_tdata,  // [7:0] status_byte, [14:8] note_number,
                                                        // [21:15] velocity
  output logic                              out_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ksme_pkg::CHAN_W-1:0]       cfg_data
);
  import ksme_pkg::*;

  ksme_cmd_t cmd;
  ksme_sts_t sts;

  // the user must write the channel only between scans; the block does not enforce it
  assign cfg_ready = 1'b1;

  ksme_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ksme_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
